// ----- src/gsc_pkg.sv -----
// Shared types and constants for the graph sequence classifier.
`timescale 1ns / 1ps
`default_nettype none

package gsc_pkg;

    // Vertex index as carried by the item fields (covers up to 64 vertices)
    localparam int VIDX_W = 6;
    localparam int COUNT_W = 8;

    localparam logic [VIDX_W-1:0]  VCOUNT_RESET = 6'd32;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'hFF;

    typedef logic [VIDX_W-1:0] t_vidx;

    // What an accepted transaction does to the sequence state
    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_FIRST,
        KIND_STEP
    } t_kind;

    // Work handed from the tracking stage to the classify stage
    typedef struct packed {
        t_kind              kind;
        logic               last;
        logic               v_ok;
        logic               pv_ok;
        t_vidx              v;
        t_vidx              lo;
        t_vidx              hi;
        logic               seen_now;
        logic               vrep;
        logic               closed_eq;
        logic [COUNT_W-1:0] steps;
    } t_stage;

    typedef struct packed {
        logic               is_walk;
        logic               is_trail;
        logic               is_path;
        logic               is_closed_walk;
        logic               is_circuit;
        logic               is_simple_circuit;
        logic [COUNT_W-1:0] edge_count;
    } t_result;

endpackage

`default_nettype wire

// ----- src/gsc_item_if.sv -----
// Input item channel: adjacency writes and sequence vertices.
`timescale 1ns / 1ps
`default_nettype none

interface gsc_item_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [4:0] row_vertex;
    logic [4:0] col_vertex;
    logic       edge_bit;
    logic [5:0] vertex;
    logic       last_vertex;

    modport source (
        output valid, mode, row_vertex, col_vertex, edge_bit, vertex, last_vertex,
        input  ready
    );
    modport sink (
        input  valid, mode, row_vertex, col_vertex, edge_bit, vertex, last_vertex,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/gsc_result_if.sv -----
// Result channel: classification flags and edge count.
`timescale 1ns / 1ps
`default_nettype none

interface gsc_result_if;
    logic       valid;
    logic       ready;
    logic       is_walk;
    logic       is_trail;
    logic       is_path;
    logic       is_closed_walk;
    logic       is_circuit;
    logic       is_simple_circuit;
    logic [7:0] edge_count;

    modport source (
        output valid, is_walk, is_trail, is_path, is_closed_walk, is_circuit,
               is_simple_circuit, edge_count,
        input  ready
    );
    modport sink (
        input  valid, is_walk, is_trail, is_path, is_closed_walk, is_circuit,
               is_simple_circuit, edge_count,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/gsc_cfg_if.sv -----
// Configuration write channel for the vertex count register.
`timescale 1ns / 1ps
`default_nettype none

interface gsc_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] vertex_count;

    modport source (output valid, vertex_count, input ready);
    modport sink (input valid, vertex_count, output ready);
endinterface

`default_nettype wire

// ----- src/graph_sequence_classifier.sv -----
// The final vertex of a sequence is loaded into the stage register, and its result then into the output register.
// Throughput: one transaction per cycle unless the input stalls, set by the used-edge memory
// read-modify-write, whose back-to-back hazard on the same row is closed by write forwarding.
// Input ready drops only while a finished result waits behind a full, stalled output register.
// Reset: control state clears, vertex_count returns to 32; per-row valid bits make both
// memories read as empty at once, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module graph_sequence_classifier #(
    parameter int MAX_VERTICES = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    gsc_item_if.sink         i_item,
    gsc_result_if.source     o_result,
    gsc_cfg_if.sink          i_cfg
);

    localparam int         IW   = $clog2(MAX_VERTICES);
    localparam logic [6:0] MAXV = 7'(MAX_VERTICES);

    gsc_pkg::t_vidx   r_vertex_count;

    logic                   accept;
    logic                   take;
    logic                   adj_wr_en;
    gsc_pkg::t_stage        stage;
    gsc_pkg::t_vidx         prev;
    logic                   clear;
    logic [MAX_VERTICES-1:0] adj_row;
    logic [MAX_VERTICES-1:0] used_row;
    logic                   used_wr_en;
    logic [IW-1:0]          used_wr_row;
    logic [MAX_VERTICES-1:0] used_wr_data;
    logic                   out_valid;
    gsc_pkg::t_result       result;

    // Vertex count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= gsc_pkg::VCOUNT_RESET;
        end else if (i_cfg.valid) begin
            r_vertex_count <= i_cfg.vertex_count;
        end
    end

    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = take;
    assign accept       = i_item.valid && take;

    // Drop adjacency writes outside the matrix
    assign adj_wr_en = accept && !i_item.mode
                       && ({2'b00, i_item.row_vertex} < MAXV)
                       && ({2'b00, i_item.col_vertex} < MAXV);

    gsc_track #(.N(MAX_VERTICES)) u_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_mode         (i_item.mode),
        .i_vertex       (i_item.vertex),
        .i_last         (i_item.last_vertex),
        .i_vertex_count (r_vertex_count),
        .o_stage        (stage),
        .o_prev         (prev),
        .o_clear        (clear)
    );

    gsc_adj_mem #(.N(MAX_VERTICES)) u_adj_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (adj_wr_en),
        .i_wr_row  (IW'(i_item.row_vertex)),
        .i_wr_col  (IW'(i_item.col_vertex)),
        .i_wr_bit  (i_item.edge_bit),
        .i_rd_en   (accept),
        .i_rd_row  (prev[IW-1:0]),
        .o_rd_data (adj_row)
    );

    gsc_used_mem #(.N(MAX_VERTICES)) u_used_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (clear),
        .i_rd_en   (accept),
        .i_rd_row  (stage.lo[IW-1:0]),
        .i_wr_en   (used_wr_en),
        .i_wr_row  (used_wr_row),
        .i_wr_data (used_wr_data),
        .o_rd_data (used_row)
    );

    gsc_classify #(.N(MAX_VERTICES)) u_classify (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_stage        (stage),
        .i_adj_row      (adj_row),
        .i_used_row     (used_row),
        .i_out_ready    (o_result.ready),
        .o_take         (take),
        .o_used_wr_en   (used_wr_en),
        .o_used_wr_row  (used_wr_row),
        .o_used_wr_data (used_wr_data),
        .o_out_valid    (out_valid),
        .o_result       (result)
    );

    // Drive the result channel from the output register
    assign o_result.valid             = out_valid;
    assign o_result.is_walk           = result.is_walk;
    assign o_result.is_trail          = result.is_trail;
    assign o_result.is_path           = result.is_path;
    assign o_result.is_closed_walk    = result.is_closed_walk;
    assign o_result.is_circuit        = result.is_circuit;
    assign o_result.is_simple_circuit = result.is_simple_circuit;
    assign o_result.edge_count        = result.edge_count;

endmodule

`default_nettype wire

// ----- src/gsc_adj_mem.sv -----
// Adjacency matrix memory: bit writes, one registered row read.
`timescale 1ns / 1ps
`default_nettype none

module gsc_adj_mem #(
    parameter int N = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr_en,
    input  wire logic [$clog2(N)-1:0] i_wr_row,
    input  wire logic [$clog2(N)-1:0] i_wr_col,
    input  wire logic                 i_wr_bit,
    input  wire logic                 i_rd_en,
    input  wire logic [$clog2(N)-1:0] i_rd_row,
    output logic [N-1:0]              o_rd_data
);

    localparam logic [N-1:0] ONE = {{(N-1){1'b0}}, 1'b1};

    logic [N-1:0] r_mem [N];
    logic [N-1:0] r_row_vld;
    logic [N-1:0] r_rd_data;
    logic         r_rd_ok;

    // Track rows written since reset; an unwritten row reads as no edges
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_wr_en) begin
            r_row_vld[i_wr_row] <= 1'b1;
        end
    end

    // Write one entry; the first write to a row sets the whole row
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            if (r_row_vld[i_wr_row]) begin
                r_mem[i_wr_row][i_wr_col] <= i_wr_bit;
            end else begin
                r_mem[i_wr_row] <= i_wr_bit ? (ONE << i_wr_col) : '0;
            end
        end
    end

    // Registered row read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_row];
            r_rd_ok   <= r_row_vld[i_rd_row];
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

`default_nettype wire

// ----- src/gsc_used_mem.sv -----
// Used-edge memory: row read with write forwarding, per-sequence row clear.
`timescale 1ns / 1ps
`default_nettype none

module gsc_used_mem #(
    parameter int N = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_clear,
    input  wire logic                 i_rd_en,
    input  wire logic [$clog2(N)-1:0] i_rd_row,
    input  wire logic                 i_wr_en,
    input  wire logic [$clog2(N)-1:0] i_wr_row,
    input  wire logic [N-1:0]         i_wr_data,
    output logic [N-1:0]              o_rd_data
);

    logic [N-1:0] r_mem [N];
    logic [N-1:0] r_row_vld;
    logic [N-1:0] r_rd_data;
    logic         r_rd_ok;
    logic         r_fwd_hit;
    logic [N-1:0] r_fwd_data;

    // Row valid bits: drop all at sequence start, set on write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_clear) begin
            r_row_vld <= '0;
        end else if (i_wr_en) begin
            r_row_vld[i_wr_row] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_row] <= i_wr_data;
        end
    end

    // Read, and capture a write-back to the same row at the same edge
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_row];
            r_rd_ok    <= r_row_vld[i_rd_row];
            r_fwd_hit  <= i_wr_en && (i_wr_row == i_rd_row);
            r_fwd_data <= i_wr_data;
        end
    end

    always_comb begin
        if (r_fwd_hit) begin
            o_rd_data = r_fwd_data;
        end else if (r_rd_ok) begin
            o_rd_data = r_rd_data;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

`default_nettype wire

// ----- src/gsc_track.sv -----
// Sequence tracking stage: start, previous vertex, visited bitmap, step count.
`timescale 1ns / 1ps
`default_nettype none

module gsc_track #(
    parameter int N = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic                  i_mode,
    input  wire gsc_pkg::t_vidx        i_vertex,
    input  wire logic                  i_last,
    input  wire gsc_pkg::t_vidx        i_vertex_count,
    output gsc_pkg::t_stage            o_stage,
    output gsc_pkg::t_vidx             o_prev,
    output logic                       o_clear
);

    localparam int           IW   = $clog2(N);
    localparam logic [6:0]   MAXV = 7'(N);
    localparam logic [N-1:0] ONE  = {{(N-1){1'b0}}, 1'b1};

    gsc_pkg::t_vidx                  r_start;
    gsc_pkg::t_vidx                  r_prev;
    logic                            r_in_seq;
    logic [gsc_pkg::COUNT_W-1:0]     r_steps;
    logic                            r_vrep;
    logic [N-1:0]                    r_visited;

    gsc_pkg::t_stage                 n_stage;
    logic                            v_ok;
    logic                            p_ok;
    logic [N-1:0]                    v_bit;

    // Classify the transaction against the current sequence state
    always_comb begin
        v_ok  = (i_vertex < i_vertex_count) && ({1'b0, i_vertex} < MAXV);
        p_ok  = (r_prev < i_vertex_count) && ({1'b0, r_prev} < MAXV);
        v_bit = v_ok ? (ONE << i_vertex[IW-1:0]) : '0;

        n_stage.last      = i_last;
        n_stage.v_ok      = v_ok;
        n_stage.pv_ok     = v_ok && p_ok;
        n_stage.v         = i_vertex;
        n_stage.lo        = (r_prev < i_vertex) ? r_prev : i_vertex;
        n_stage.hi        = (r_prev < i_vertex) ? i_vertex : r_prev;
        n_stage.seen_now  = v_ok && r_visited[i_vertex[IW-1:0]];
        n_stage.closed_eq = (i_vertex == r_start);
        if (!i_mode) begin
            n_stage.kind  = gsc_pkg::KIND_WRITE;
            n_stage.vrep  = 1'b0;
            n_stage.steps = '0;
        end else if (!r_in_seq) begin
            n_stage.kind  = gsc_pkg::KIND_FIRST;
            n_stage.vrep  = 1'b0;
            n_stage.steps = '0;
        end else begin
            n_stage.kind  = gsc_pkg::KIND_STEP;
            n_stage.vrep  = r_vrep;
            n_stage.steps = (r_steps == gsc_pkg::COUNT_MAX) ? r_steps : r_steps + 1'b1;
        end
    end

    // Advance the sequence state on each accepted vertex
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= '0;
            r_prev    <= '0;
            r_in_seq  <= 1'b0;
            r_steps   <= '0;
            r_vrep    <= 1'b0;
            r_visited <= '0;
        end else if (i_accept && i_mode) begin
            r_prev   <= i_vertex;
            r_in_seq <= !i_last;
            r_steps  <= n_stage.steps;
            if (n_stage.kind == gsc_pkg::KIND_FIRST) begin
                r_start   <= i_vertex;
                r_vrep    <= 1'b0;
                r_visited <= v_bit;
            end else if (!i_last) begin
                r_vrep    <= r_vrep || n_stage.seen_now;
                r_visited <= r_visited | v_bit;
            end
        end
    end

    assign o_stage = n_stage;
    assign o_prev  = r_prev;
    assign o_clear = i_accept && (n_stage.kind == gsc_pkg::KIND_FIRST);

endmodule

`default_nettype wire

// ----- src/gsc_classify.sv -----
// Classify stage: edge checks on memory rows, used-edge write-back, result register.
`timescale 1ns / 1ps
`default_nettype none

module gsc_classify #(
    parameter int N = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire gsc_pkg::t_stage      i_stage,
    input  wire logic [N-1:0]         i_adj_row,
    input  wire logic [N-1:0]         i_used_row,
    input  wire logic                 i_out_ready,
    output logic                      o_take,
    output logic                      o_used_wr_en,
    output logic [$clog2(N)-1:0]      o_used_wr_row,
    output logic [N-1:0]              o_used_wr_data,
    output logic                      o_out_valid,
    output gsc_pkg::t_result          o_result
);

    localparam int           IW  = $clog2(N);
    localparam logic [N-1:0] ONE = {{(N-1){1'b0}}, 1'b1};

    gsc_pkg::t_stage  r_s1;
    logic             r_s1_vld;
    logic             r_walk_ok;
    logic             r_erep;
    logic             r_out_vld;
    gsc_pkg::t_result r_out;

    gsc_pkg::t_result n_res;
    logic             has_res;
    logic             advance;
    logic             step_ok;
    logic             rep_now;
    logic             walk;
    logic             trail;
    logic             closed;

    // Evaluate the step held in the stage register
    always_comb begin
        step_ok = r_s1.pv_ok && i_adj_row[r_s1.v[IW-1:0]];
        rep_now = r_s1.pv_ok && i_used_row[r_s1.hi[IW-1:0]];
        walk    = r_walk_ok && step_ok;
        trail   = walk && !(r_erep || rep_now);
        closed  = walk && r_s1.closed_eq;

        has_res = r_s1_vld && r_s1.last && (r_s1.kind != gsc_pkg::KIND_WRITE);
        advance = !has_res || !r_out_vld || i_out_ready;

        n_res = '0;
        if (r_s1.kind == gsc_pkg::KIND_STEP) begin
            n_res.is_walk           = walk;
            n_res.is_trail          = trail;
            n_res.is_path           = walk && !r_s1.vrep && !r_s1.seen_now;
            n_res.is_closed_walk    = closed;
            n_res.is_circuit        = closed && trail;
            n_res.is_simple_circuit = closed && !r_s1.vrep;
            n_res.edge_count        = r_s1.steps;
        end

        o_used_wr_en   = r_s1_vld && advance && (r_s1.kind == gsc_pkg::KIND_STEP)
                         && r_s1.pv_ok;
        o_used_wr_row  = r_s1.lo[IW-1:0];
        o_used_wr_data = i_used_row | (ONE << r_s1.hi[IW-1:0]);
    end

    // Load the stage register on accept
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1 <= i_stage;
        end
    end

    // Stage occupancy and per-sequence walk flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_walk_ok <= 1'b1;
            r_erep    <= 1'b0;
        end else begin
            if (i_accept) begin
                r_s1_vld <= 1'b1;
            end else if (advance) begin
                r_s1_vld <= 1'b0;
            end
            if (r_s1_vld && advance) begin
                case (r_s1.kind)
                    gsc_pkg::KIND_FIRST: begin
                        r_walk_ok <= r_s1.v_ok;
                        r_erep    <= 1'b0;
                    end
                    gsc_pkg::KIND_STEP: begin
                        r_walk_ok <= r_walk_ok && step_ok;
                        r_erep    <= r_erep || rep_now;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Output register: load a finished result, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (has_res && advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (has_res && advance) begin
            r_out <= n_res;
        end
    end

    assign o_take      = advance;
    assign o_out_valid = r_out_vld;
    assign o_result    = r_out;

endmodule

`default_nettype wire

// ----- src/gsc_checker.sv -----
// Port-level checks for the graph sequence classifier, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module gsc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic       i_is_walk,
    input wire logic       i_is_trail,
    input wire logic       i_is_path,
    input wire logic       i_is_closed_walk,
    input wire logic       i_is_circuit,
    input wire logic       i_is_simple_circuit,
    input wire logic [7:0] i_edge_count
);

    // Hold a stalled result transaction unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable(i_edge_count) && $stable(i_is_walk) && $stable(i_is_circuit))
        else $error("stalled result changed");

    // A new result follows an accepted input transaction
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result without a preceding input transaction");

    // Stall the input only while a result waits to be taken
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled with output free");

    // Flags nest: every class implies a walk with at least one step
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (!i_is_walk || i_edge_count != 8'd0)
            && (!(i_is_trail || i_is_path || i_is_closed_walk) || i_is_walk)
            && (!i_is_circuit || (i_is_closed_walk && i_is_trail))
            && (!i_is_simple_circuit || i_is_closed_walk))
        else $error("inconsistent classification flags");

endmodule

bind graph_sequence_classifier gsc_checker u_gsc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_item.valid),
    .i_in_ready          (i_item.ready),
    .i_out_valid         (o_result.valid),
    .i_out_ready         (o_result.ready),
    .i_is_walk           (o_result.is_walk),
    .i_is_trail          (o_result.is_trail),
    .i_is_path           (o_result.is_path),
    .i_is_closed_walk    (o_result.is_closed_walk),
    .i_is_circuit        (o_result.is_circuit),
    .i_is_simple_circuit (o_result.is_simple_circuit),
    .i_edge_count        (o_result.edge_count)
);

`default_nettype wire
